// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("next-cycle check failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, lhs, rhs)
`define ASSERT_NEXT(label, clk, rst, lhs, rhs)

`endif

`endif

// ===== rtl/fe3w_pkg.sv =====
// ----------------------------------------------------------------------------
// fe3w_pkg
// Shared constants and types of the empty 3x3 window search.
// ----------------------------------------------------------------------------
package fe3w_pkg;

   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;

   localparam logic [7:0] EMPTY_CODE     = 8'd32;
   localparam int         EXCLUDE_RADIUS = 4;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REG_MAP_WIDTH      = 3'd0,
      REG_MAP_HEIGHT     = 3'd1,
      REG_EXCLUDE_ENABLE = 3'd2,
      REG_EXCLUDE_COL    = 3'd3,
      REG_EXCLUDE_ROW    = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [8:0] map_width;
      logic [8:0] map_height;
      logic       exclude_enable;
      logic [7:0] exclude_col;
      logic [7:0] exclude_row;
   } cfg_type;

   localparam logic [8:0] MAP_WIDTH_RST  = 9'd256;
   localparam logic [8:0] MAP_HEIGHT_RST = 9'd256;

endpackage

// ===== rtl/fe3w_ram.sv =====
// ----------------------------------------------------------------------------
// fe3w_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fe3w_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/fe3w_csr.sv =====
// ----------------------------------------------------------------------------
// fe3w_csr
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
module fe3w_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [fe3w_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [fe3w_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [fe3w_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output fe3w_pkg::cfg_type                cfg
);

   fe3w_pkg::cfg_type cfg_ff;
   fe3w_pkg::cfg_type cfg_in;
   logic [2:0]        reg_idx;
   logic              wr_hit;

   assign reg_idx    = csr_paddr[4:2];
   assign wr_hit     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_hit) begin
         case (reg_idx)
            fe3w_pkg::REG_MAP_WIDTH:      cfg_in.map_width      = csr_pwdata[8:0];
            fe3w_pkg::REG_MAP_HEIGHT:     cfg_in.map_height     = csr_pwdata[8:0];
            fe3w_pkg::REG_EXCLUDE_ENABLE: cfg_in.exclude_enable = csr_pwdata[0];
            fe3w_pkg::REG_EXCLUDE_COL:    cfg_in.exclude_col    = csr_pwdata[7:0];
            fe3w_pkg::REG_EXCLUDE_ROW:    cfg_in.exclude_row    = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (reg_idx)
         fe3w_pkg::REG_MAP_WIDTH:      csr_prdata = 32'(cfg_ff.map_width);
         fe3w_pkg::REG_MAP_HEIGHT:     csr_prdata = 32'(cfg_ff.map_height);
         fe3w_pkg::REG_EXCLUDE_ENABLE: csr_prdata = 32'(cfg_ff.exclude_enable);
         fe3w_pkg::REG_EXCLUDE_COL:    csr_prdata = 32'(cfg_ff.exclude_col);
         fe3w_pkg::REG_EXCLUDE_ROW:    csr_prdata = 32'(cfg_ff.exclude_row);
         default:                      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.map_width      <= fe3w_pkg::MAP_WIDTH_RST;
         cfg_ff.map_height     <= fe3w_pkg::MAP_HEIGHT_RST;
         cfg_ff.exclude_enable <= 1'b0;
         cfg_ff.exclude_col    <= '0;
         cfg_ff.exclude_row    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/fe3w_scan.sv =====
// ----------------------------------------------------------------------------
// fe3w_scan
// Raster position counters, line-buffer read-modify-write and window check.
// ----------------------------------------------------------------------------
module fe3w_scan #(
   parameter int MAX_WIDTH  = fe3w_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = fe3w_pkg::MAX_HEIGHT_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  fe3w_pkg::cfg_type            cfg,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [15:0]                  rsp_tdata,
   output logic                         rsp_tuser,
   // line buffer port, bit 0 row above, bit 1 two rows above
   output logic                         lb_wr_en,
   output logic [$clog2(MAX_WIDTH)-1:0] lb_wr_addr,
   output logic [1:0]                   lb_wr_data,
   output logic                         lb_rd_en,
   output logic [$clog2(MAX_WIDTH)-1:0] lb_rd_addr,
   input  logic [1:0]                   lb_rd_data
);

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int RW   = $clog2(MAX_HEIGHT);
   localparam int CMPC = (CW + 1 > 9) ? CW + 1 : 9;
   localparam int CMPR = (RW + 1 > 9) ? RW + 1 : 9;
   localparam int XC   = (CW > 8) ? CW : 8;
   localparam int XR   = (RW > 8) ? RW : 8;

   // front stage: position counters
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW:0]   fill_ff, fill_in;
   logic          accept, last_col, last_row, fwd_hit, rd_ok;

   // back stage: line-buffer data arrives here
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_cur_ff;
   logic [CW-1:0] s1_col_ff;
   logic [RW-1:0] s1_row_ff;
   logic          s1_last_col_ff, s1_last_row_ff;
   logic          s1_fwd_ff, s1_rd_ok_ff;
   logic [1:0]    s1_fwd_data_ff;
   logic          s1_go, s1_end;

   logic [1:0]    lb_eff;
   logic          col_flag, skip, hit_now;
   logic [CW-1:0] cx;
   logic [RW-1:0] cy;
   logic [XC-1:0] cx_x, ex_col_x, d_col;
   logic [XR-1:0] cy_x, ex_row_x, d_row;

   logic [1:0]    recent_ff, recent_in;
   logic          hit_seen_ff, hit_seen_in, hit_seen_new;
   logic [7:0]    hit_col_ff, hit_col_in, hit_col_new;
   logic [7:0]    hit_row_ff, hit_row_in, hit_row_new;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_found_ff, rsp_found_in;
   logic [7:0]    rsp_col_ff, rsp_col_in;
   logic [7:0]    rsp_row_ff, rsp_row_in;

   // a waiting result only holds back a second map end
   assign s1_end     = s1_last_col_ff && s1_last_row_ff;
   assign s1_go      = s1_valid_ff && (!s1_end || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_go;
   assign accept     = req_tvalid && req_tready;

   // a zero size register ends every row / map at once
   assign last_col = (col_ff == CW'(MAX_WIDTH - 1)) ||
                     (CMPC'(col_ff) + CMPC'(1) >= CMPC'(cfg.map_width));
   assign last_row = (row_ff == RW'(MAX_HEIGHT - 1)) ||
                     (CMPR'(row_ff) + CMPR'(1) >= CMPR'(cfg.map_height));

   // columns are always written in ascending order, so written entries form a prefix
   assign rd_ok   = (CW'(0) == CW'(0)) && ((CW + 1)'(col_ff) < fill_ff);
   assign fwd_hit = s1_go && (s1_col_ff == col_ff);

   assign lb_rd_en   = accept;
   assign lb_rd_addr = col_ff;

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      if (accept) begin
         if (!last_col) begin
            col_in = col_ff + CW'(1);
         end else begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + RW'(1);
         end
      end
   end

   assign s1_valid_in = accept || (s1_valid_ff && !s1_go);

   // back stage: window check
   always_comb begin
      if (s1_fwd_ff) begin
         lb_eff = s1_fwd_data_ff;
      end else if (s1_rd_ok_ff) begin
         lb_eff = lb_rd_data;
      end else begin
         lb_eff = 2'b00;
      end
   end

   assign col_flag = s1_cur_ff && lb_eff[0] && lb_eff[1];
   assign cx       = s1_col_ff - CW'(1);
   assign cy       = s1_row_ff - RW'(1);
   assign cx_x     = XC'(cx);
   assign cy_x     = XR'(cy);
   assign ex_col_x = XC'(cfg.exclude_col);
   assign ex_row_x = XR'(cfg.exclude_row);
   assign d_col    = (cx_x > ex_col_x) ? cx_x - ex_col_x : ex_col_x - cx_x;
   assign d_row    = (cy_x > ex_row_x) ? cy_x - ex_row_x : ex_row_x - cy_x;
   assign skip     = cfg.exclude_enable &&
                     (d_col <= XC'(fe3w_pkg::EXCLUDE_RADIUS)) &&
                     (d_row <= XR'(fe3w_pkg::EXCLUDE_RADIUS));

   assign hit_now = !hit_seen_ff && (s1_row_ff >= RW'(3)) && (s1_col_ff >= CW'(3)) &&
                    col_flag && (recent_ff == 2'b11) && !skip;

   assign hit_seen_new = hit_seen_ff || hit_now;
   assign hit_col_new  = hit_now ? cx_x[7:0] : hit_col_ff;
   assign hit_row_new  = hit_now ? cy_x[7:0] : hit_row_ff;

   assign lb_wr_en   = s1_go;
   assign lb_wr_addr = s1_col_ff;
   assign lb_wr_data = {lb_eff[0], s1_cur_ff};

   always_comb begin
      recent_in    = recent_ff;
      hit_seen_in  = hit_seen_ff;
      hit_col_in   = hit_col_ff;
      hit_row_in   = hit_row_ff;
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_found_in = rsp_found_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      if (s1_go) begin
         recent_in   = s1_last_col_ff ? 2'b00 : {recent_ff[0], col_flag};
         hit_seen_in = hit_seen_new;
         hit_col_in  = hit_col_new;
         hit_row_in  = hit_row_new;
         if ((CW + 1)'(s1_col_ff) == fill_ff) begin
            fill_in = fill_ff + (CW + 1)'(1);
         end
         if (s1_end) begin
            rsp_valid_in = 1'b1;
            rsp_found_in = hit_seen_new;
            rsp_col_in   = hit_seen_new ? hit_col_new : 8'd0;
            rsp_row_in   = hit_seen_new ? hit_row_new : 8'd0;
            hit_seen_in  = 1'b0;
            hit_col_in   = 8'd0;
            hit_row_in   = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         fill_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         recent_ff    <= 2'b00;
         hit_seen_ff  <= 1'b0;
         hit_col_ff   <= 8'd0;
         hit_row_ff   <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         fill_ff      <= fill_in;
         s1_valid_ff  <= s1_valid_in;
         recent_ff    <= recent_in;
         hit_seen_ff  <= hit_seen_in;
         hit_col_ff   <= hit_col_in;
         hit_row_ff   <= hit_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cur_ff      <= (req_tdata == fe3w_pkg::EMPTY_CODE);
         s1_col_ff      <= col_ff;
         s1_row_ff      <= row_ff;
         s1_last_col_ff <= last_col;
         s1_last_row_ff <= last_row;
         s1_rd_ok_ff    <= rd_ok;
         // same column written back this cycle: RAM still returns the old word
         s1_fwd_ff      <= fwd_hit;
         s1_fwd_data_ff <= lb_wr_data;
      end
      rsp_found_ff <= rsp_found_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_row_ff   <= rsp_row_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {rsp_row_ff, rsp_col_ff};

endmodule

// ===== rtl/first_empty_3x3_window_search.sv =====
// ----------------------------------------------------------------------------
// first_empty_3x3_window_search
// Finds the first all-space 3x3 window of a raster character map.
// ----------------------------------------------------------------------------
// Takes one cell per clock, sustained, and answers once per map with the
// centre of the first all-empty window, registered from the back stage on
// the last cell of a map. The rate is set by the line buffer: one 2-bit
// wide, MAX_WIDTH deep RAM holding the empty flags of the two rows above,
// read when a cell is taken and written back from the back stage, with the
// write forwarded when the next cell hits the same column. The RAM needs no
// clearing pass after reset: a fill count marks the columns written so far.
// The input stalls only when a map end meets an earlier result not yet taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module first_empty_3x3_window_search #(
   parameter int MAX_WIDTH  = fe3w_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = fe3w_pkg::MAX_HEIGHT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,   // [7:0] cell_code
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [15:0]                      rsp_tdata,   // [7:0] centre_col, [15:8] centre_row
   output logic                             rsp_tuser,   // [0] found
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [fe3w_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [fe3w_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [fe3w_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);

   localparam int CW = $clog2(MAX_WIDTH);

   fe3w_pkg::cfg_type cfg;
   logic              lb_wr_en, lb_rd_en;
   logic [CW-1:0]     lb_wr_addr, lb_rd_addr;
   logic [1:0]        lb_wr_data, lb_rd_data;

   fe3w_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   fe3w_ram #(
      .WIDTH (2),
      .DEPTH (MAX_WIDTH)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (lb_wr_en),
      .wr_addr (lb_wr_addr),
      .wr_data (lb_wr_data),
      .rd_en   (lb_rd_en),
      .rd_addr (lb_rd_addr),
      .rd_data (lb_rd_data)
   );

   fe3w_scan #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .lb_wr_en   (lb_wr_en),
      .lb_wr_addr (lb_wr_addr),
      .lb_wr_data (lb_wr_data),
      .lb_rd_en   (lb_rd_en),
      .lb_rd_addr (lb_rd_addr),
      .lb_rd_data (lb_rd_data)
   );

   // input only stalls behind a result that is waiting on the output
   `ASSERT_IMPLIES(a_stall_cause, clock, reset, !req_tready, rsp_tvalid && !rsp_tready)

   // no window found means a zero centre
   `ASSERT_IMPLIES(a_miss_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == 16'd0)

   // the line buffer is only read when a cell is taken
   `ASSERT_IMPLIES(a_read_on_accept, clock, reset, lb_rd_en, req_tvalid && req_tready)

   // a taken cell is written back next cycle unless the input is stalled
   `ASSERT_NEXT(a_writeback, clock, reset, req_tvalid && req_tready,
                lb_wr_en || !req_tready)

endmodule

// ===== bench/first_empty_3x3_window_search_tb.sv =====
// ----------------------------------------------------------------------------
// first_empty_3x3_window_search_tb
// Self-checking bench for the empty 3x3 window search.
// ----------------------------------------------------------------------------
// Streams character maps into the block under a range of map sizes and
// exclusion settings and checks every result word against a local model of
// the search. Registers change only while the block is drained. Both stream
// sides idle at random, and one phase holds the result side off long enough
// to stall the input.
// ----------------------------------------------------------------------------
module first_empty_3x3_window_search_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_CELLS = 300;
   localparam int unsigned MIN_RESULTS  = 40;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned HOLD_CYCLES  = 200;
   localparam int unsigned CYCLE_LIMIT  = 2_000_000;
   localparam int unsigned FIRST_UNUSED_ADDR = (int'(fe3w_pkg::REG_EXCLUDE_ROW) + 1) * 4;
   localparam int unsigned ADDR_SPAN = 1 << fe3w_pkg::CSR_ADDR_W;

   typedef struct {
      logic       found;
      logic [7:0] centre_col;
      logic [7:0] centre_row;
   } search_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata = '0;     // [7:0] cell_code
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [15:0]            rsp_tdata;          // [7:0] centre_col, [15:8] centre_row
   logic                   rsp_tuser;          // [0] found
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [fe3w_pkg::CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [fe3w_pkg::CSR_DATA_W-1:0]  csr_pwdata = '0;
   logic [fe3w_pkg::CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   // stimulus control
   logic [7:0]        cell_queue[$];
   search_result_type pending_windows[$];
   bit             gaps_on = 1'b0;
   bit             stalls_on = 1'b0;
   bit             hold_go = 1'b0;
   logic           rsp_hold = 1'b0;
   int unsigned    gap_left = 0;
   int unsigned    stall_left = 0;
   int unsigned    mismatch_count = 0;
   int unsigned    cycle_count = 0;
   int unsigned    results_total = 0;

   // local copy of the block's registers and search state
   logic [8:0]   cfg_width = fe3w_pkg::MAP_WIDTH_RST;
   logic [8:0]   cfg_height = fe3w_pkg::MAP_HEIGHT_RST;
   logic         cfg_excl_en = 1'b0;
   logic [7:0]   cfg_excl_col = '0;
   logic [7:0]   cfg_excl_row = '0;
   bit [fe3w_pkg::MAX_WIDTH_DEF-1:0] empty_row1 = '0;
   bit [fe3w_pkg::MAX_WIDTH_DEF-1:0] empty_row2 = '0;
   int unsigned  col_pos = 0;
   int unsigned  row_pos = 0;
   bit [1:0]     column_run = '0;
   bit           hit_seen = 1'b0;
   logic [7:0]   hit_col = '0;
   logic [7:0]   hit_row = '0;

   first_empty_3x3_window_search i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned eff_size(input logic [8:0] v, input int unsigned limit);
      if (v == 0)
         return 1;
      return (v > limit) ? limit : int'(v);
   endfunction

   function automatic int unsigned axis_gap(input int unsigned a, input int unsigned b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [7:0] random_cell(input int unsigned busy_pct);
      if ($urandom_range(99) >= busy_pct)
         return fe3w_pkg::EMPTY_CODE;
      // near misses of the space code flip one bit
      if ($urandom_range(1) == 1)
         return fe3w_pkg::EMPTY_CODE ^ (8'd1 << $urandom_range(7));
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [8:0] pick_size();
      case ($urandom_range(9))
         0:       return 9'd0;
         1, 2:    return 9'($urandom_range(1, 3));
         default: return 9'($urandom_range(4, 14));
      endcase
   endfunction

   function automatic void apply_register(input logic [fe3w_pkg::CSR_ADDR_W-1:0] addr,
                                          input logic [fe3w_pkg::CSR_DATA_W-1:0] data);
      case (fe3w_pkg::reg_index_type'(addr[4:2]))
         fe3w_pkg::REG_MAP_WIDTH:      cfg_width = data[8:0];
         fe3w_pkg::REG_MAP_HEIGHT:     cfg_height = data[8:0];
         fe3w_pkg::REG_EXCLUDE_ENABLE: cfg_excl_en = data[0];
         fe3w_pkg::REG_EXCLUDE_COL:    cfg_excl_col = data[7:0];
         fe3w_pkg::REG_EXCLUDE_ROW:    cfg_excl_row = data[7:0];
         default: ;
      endcase
   endfunction

   // advance the window search by one cell, queue the map result on its last cell
   function automatic void track_cell(input logic [7:0] code);
      int unsigned       w, h, ci, cx, cy;
      bit                here, col_ok, skip;
      search_result_type res;
      w = eff_size(cfg_width, fe3w_pkg::MAX_WIDTH_DEF);
      h = eff_size(cfg_height, fe3w_pkg::MAX_HEIGHT_DEF);
      ci = (col_pos < fe3w_pkg::MAX_WIDTH_DEF) ? col_pos : fe3w_pkg::MAX_WIDTH_DEF - 1;
      here = (code == fe3w_pkg::EMPTY_CODE);
      col_ok = here & empty_row1[ci] & empty_row2[ci];
      if (!hit_seen && row_pos >= 3 && col_pos >= 3 && col_ok && column_run == 2'b11) begin
         cx = col_pos - 1;
         cy = row_pos - 1;
         skip = cfg_excl_en && axis_gap(cfg_excl_col, cx) <= fe3w_pkg::EXCLUDE_RADIUS
                && axis_gap(cfg_excl_row, cy) <= fe3w_pkg::EXCLUDE_RADIUS;
         if (!skip) begin
            hit_seen = 1'b1;
            hit_col = 8'(cx);
            hit_row = 8'(cy);
         end
      end
      empty_row2[ci] = empty_row1[ci];
      empty_row1[ci] = here;
      column_run = {column_run[0], col_ok};
      if (col_pos + 1 < w) begin
         col_pos++;
      end else begin
         col_pos = 0;
         column_run = '0;
         if (row_pos + 1 < h) begin
            row_pos++;
         end else begin
            res.found = hit_seen;
            res.centre_col = hit_seen ? hit_col : 8'd0;
            res.centre_row = hit_seen ? hit_row : 8'd0;
            pending_windows = {pending_windows, res};
            results_total++;
            row_pos = 0;
            hit_seen = 1'b0;
            hit_col = '0;
            hit_row = '0;
         end
      end
   endfunction

   always @(posedge clock) begin : cell_driver
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left <= 0;
      end else begin
         if (req_tvalid && req_tready)
            track_cell(req_tdata);
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               req_tvalid <= 1'b0;
               gap_left <= gap_left - 1;
            end else if (cell_queue.size() != 0) begin
               req_tvalid <= 1'b1;
               req_tdata <= cell_queue.pop_front();
               gap_left <= gaps_on ? pick_gap() : 0;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : result_monitor
      search_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_windows.size() == 0) begin
               $error("unexpected result word: found=%0d centre_col=%0d centre_row=%0d",
                      rsp_tuser, rsp_tdata[7:0], rsp_tdata[15:8]);
               mismatch_count++;
            end else begin
               want = pending_windows.pop_front();
               if (rsp_tuser !== want.found) begin
                  $error("found: expected %0d, actual %0d", want.found, rsp_tuser);
                  mismatch_count++;
               end
               if (rsp_tdata[7:0] !== want.centre_col) begin
                  $error("centre_col: expected %0d, actual %0d", want.centre_col,
                         rsp_tdata[7:0]);
                  mismatch_count++;
               end
               if (rsp_tdata[15:8] !== want.centre_row) begin
                  $error("centre_row: expected %0d, actual %0d", want.centre_row,
                         rsp_tdata[15:8]);
                  mismatch_count++;
               end
            end
         end
         if (rsp_hold || stall_left != 0) begin
            rsp_tready <= 1'b0;
            if (stall_left != 0)
               stall_left <= stall_left - 1;
         end else begin
            rsp_tready <= 1'b1;
            stall_left <= stalls_on ? pick_gap() : 0;
         end
      end
   end

   // long hold-off on the result side, started once by the stimulus
   initial begin : receiver_hold
      wait (hold_go);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic csr_write(input logic [fe3w_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [fe3w_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      apply_register(addr, data);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic write_reg(input fe3w_pkg::reg_index_type idx,
                            input logic [fe3w_pkg::CSR_DATA_W-1:0] data);
      csr_write({idx, 2'b00}, data);
   endtask

   task automatic configure(input logic [8:0] w, input logic [8:0] h, input logic en,
                            input logic [7:0] xc, input logic [7:0] xr);
      write_reg(fe3w_pkg::REG_MAP_WIDTH, 32'(w));
      write_reg(fe3w_pkg::REG_MAP_HEIGHT, 32'(h));
      write_reg(fe3w_pkg::REG_EXCLUDE_ENABLE, 32'(en));
      write_reg(fe3w_pkg::REG_EXCLUDE_COL, 32'(xc));
      write_reg(fe3w_pkg::REG_EXCLUDE_ROW, 32'(xr));
   endtask

   // block drained: no word queued or offered, every result in
   task automatic wait_idle();
      do
         @(negedge clock);
      while (cell_queue.size() != 0 || req_tvalid || pending_windows.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic feed_random(input int unsigned count, input int unsigned busy_pct);
      @(negedge clock);
      repeat (count) cell_queue = {cell_queue, random_cell(busy_pct)};
      wait_idle();
   endtask

   task automatic feed_same(input logic [7:0] code, input int unsigned count);
      @(negedge clock);
      repeat (count) cell_queue = {cell_queue, code};
      wait_idle();
   endtask

   task automatic random_phase(input logic [8:0] w, input logic [8:0] h, input logic en,
                               input logic [7:0] xc, input logic [7:0] xr,
                               input int unsigned count);
      configure(w, h, en, xc, xr);
      @(negedge clock);
      gaps_on = ($urandom_range(3) != 0);
      stalls_on = ($urandom_range(3) != 0);
      feed_random(count, $urandom_range(0, 40));
   endtask

   initial begin : stimulus
      int unsigned random_cells;
      int unsigned cells;
      logic [8:0]  w, h;
      random_cells = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // partial row at the reset size, then the size drops under the column count
      @(negedge clock);
      cell_queue = {cell_queue, 8'h00, 8'hFF, fe3w_pkg::EMPTY_CODE};
      wait_idle();

      // one-cell maps, upper data bits of the size writes dropped
      write_reg(fe3w_pkg::REG_MAP_WIDTH, 32'hFFFF_FE01);
      write_reg(fe3w_pkg::REG_MAP_HEIGHT, 32'hFFFF_FE01);
      write_reg(fe3w_pkg::REG_EXCLUDE_ENABLE, 32'hFFFF_FFFE);
      write_reg(fe3w_pkg::REG_EXCLUDE_COL, 32'hFFFF_FF00);
      write_reg(fe3w_pkg::REG_EXCLUDE_ROW, 32'hFFFF_FF00);
      @(negedge clock);
      cell_queue = {cell_queue, 8'hFF, 8'h00, fe3w_pkg::EMPTY_CODE};
      wait_idle();

      // writes outside the register map are ignored
      for (int unsigned a = FIRST_UNUSED_ADDR; a < ADDR_SPAN; a += 4)
         csr_write(fe3w_pkg::CSR_ADDR_W'(a), 32'hFFFF_FFFF);

      // smallest map holding a window, found and then excluded
      configure(9'd4, 9'd4, 1'b0, 8'd255, 8'd255);
      feed_same(fe3w_pkg::EMPTY_CODE, 16);
      configure(9'd4, 9'd4, 1'b1, 8'd0, 8'd0);
      feed_same(fe3w_pkg::EMPTY_CODE, 16);

      // zero sizes act as one
      configure(9'd0, 9'd0, 1'b0, 8'd0, 8'd0);
      feed_same(8'h20, 2);

      // result side held off while the sender keeps offering words
      configure(9'd1, 9'd1, 1'b0, 8'd0, 8'd0);
      @(negedge clock);
      gaps_on = 1'b0;
      stalls_on = 1'b0;
      hold_go = 1'b1;
      feed_random(40, 50);

      // widest and tallest maps, sizes above the maximum saturate
      random_phase(9'h1FF, 9'd4, 1'b1, 8'd255, 8'd2, 256 * 4);
      random_phase(9'd1, 9'd300, 1'b1, 8'd0, 8'd128, 256);

      while (random_cells < RANDOM_CELLS || results_total < MIN_RESULTS) begin
         w = pick_size();
         h = pick_size();
         cells = eff_size(w, fe3w_pkg::MAX_WIDTH_DEF) * eff_size(h, fe3w_pkg::MAX_HEIGHT_DEF);
         // sometimes stop inside a map so the next sizes apply mid-map
         if ($urandom_range(3) == 0)
            cells = $urandom_range(1, 4) * cells + $urandom_range(1, cells);
         else
            cells = $urandom_range(1, 4) * cells;
         if ($urandom_range(3) == 0)
            random_phase(w, h, 1'($urandom_range(1)), 8'($urandom_range(255)),
                         8'($urandom_range(255)), cells);
         else
            random_phase(w, h, 1'($urandom_range(1)), 8'($urandom_range(w + 3)),
                         8'($urandom_range(h + 3)), cells);
         random_cells += cells;
      end

      wait_idle();
      if (mismatch_count == 0 && pending_windows.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
